[src/aavr_pkg.sv]
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared widths, CORDIC constants and the arctangent table for the axis-angle rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int unsigned CompWidth   = 24;
  localparam int unsigned AngleBits   = 16;
  localparam int unsigned AxisWidth   = 16;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicW     = 33;
  localparam int unsigned PhaseW      = 32;

  localparam logic signed [CordicW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [CordicW-1:0] OneQ30     = 33'sd1073741824;

  function automatic logic signed [PhaseW:0] atan_turn(input int unsigned idx);
    logic signed [PhaseW:0] t;
    t = '0;
    case (idx)
      0:  t = 33'sd536870912;
      1:  t = 33'sd316933406;
      2:  t = 33'sd167458907;
      3:  t = 33'sd85004756;
      4:  t = 33'sd42667331;
      5:  t = 33'sd21354465;
      6:  t = 33'sd10679838;
      7:  t = 33'sd5340245;
      8:  t = 33'sd2670163;
      9:  t = 33'sd1335087;
      10: t = 33'sd667544;
      11: t = 33'sd333772;
      12: t = 33'sd166886;
      13: t = 33'sd83443;
      14: t = 33'sd41722;
      15: t = 33'sd20861;
      16: t = 33'sd10430;
      17: t = 33'sd5215;
      18: t = 33'sd2608;
      19: t = 33'sd1304;
      20: t = 33'sd652;
      21: t = 33'sd326;
      22: t = 33'sd163;
      23: t = 33'sd81;
      24: t = 33'sd41;
      25: t = 33'sd20;
      26: t = 33'sd10;
      27: t = 33'sd5;
      28: t = 33'sd3;
      29: t = 33'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[src/aavr_if.sv]
// ----------------------------------------------------------------------------
// aavr_in_if / aavr_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface aavr_in_if #(
  parameter int unsigned COMP_WIDTH = aavr_pkg::CompWidth,
  parameter int unsigned ANGLE_BITS = aavr_pkg::AngleBits
);
  logic                                   valid;
  logic                                   ready;
  logic signed [COMP_WIDTH-1:0]           vec_x;
  logic signed [COMP_WIDTH-1:0]           vec_y;
  logic signed [COMP_WIDTH-1:0]           vec_z;
  logic        [ANGLE_BITS-1:0]           rot_angle;
  logic signed [aavr_pkg::AxisWidth-1:0]  axis_x;
  logic signed [aavr_pkg::AxisWidth-1:0]  axis_y;
  logic signed [aavr_pkg::AxisWidth-1:0]  axis_z;

  modport source (output valid, vec_x, vec_y, vec_z, rot_angle, axis_x, axis_y, axis_z,
                  input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, rot_angle, axis_x, axis_y, axis_z,
                  output ready);
endinterface

interface aavr_out_if #(
  parameter int unsigned COMP_WIDTH = aavr_pkg::CompWidth
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] out_x;
  logic signed [COMP_WIDTH-1:0] out_y;
  logic signed [COMP_WIDTH-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

[src/axis_angle_vector_rotation.sv]
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rodrigues rotation of a vector by minus the angle about a unit axis.
// Stages from input accept to result valid: 1 phase, 30 CORDIC, 1 fix-up,
// 3 matrix, 3 product/sum, 1 saturate. Throughput: one item per cycle, set by
// the fully pipelined CORDIC; an output stall freezes every stage together.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation #(
  parameter int unsigned COMP_WIDTH = aavr_pkg::CompWidth,
  parameter int unsigned ANGLE_BITS = aavr_pkg::AngleBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  aavr_in_if.sink    in_i,
  aavr_out_if.source out_o
);

  localparam int unsigned Steps = aavr_pkg::CordicSteps;
  localparam int unsigned CW    = aavr_pkg::CordicW;
  localparam int unsigned PW    = aavr_pkg::PhaseW;
  localparam int unsigned AW    = aavr_pkg::AxisWidth;
  localparam int unsigned NPost = 8;
  // Vector split: high part above 24 low bits
  localparam int unsigned VhW   = (COMP_WIDTH > 24) ? COMP_WIDTH - 24 : 1;
  localparam int unsigned PrW   = 64;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] vx;
    logic signed [COMP_WIDTH-1:0] vy;
    logic signed [COMP_WIDTH-1:0] vz;
    logic signed [AW-1:0]         ax;
    logic signed [AW-1:0]         ay;
    logic signed [AW-1:0]         az;
  } side_t;

  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- phase stage
  logic            p_vld_q;
  side_t           p_side_q;
  logic [1:0]      p_quad_q;
  logic signed [PW:0] p_res_q;
  logic [ANGLE_BITS-1:0] neg_ang;
  logic [PW-1:0]   ph, tph;

  always_comb begin
    neg_ang = ANGLE_BITS'(0) - in_i.rot_angle;
    ph = PW'(neg_ang) << (PW - ANGLE_BITS);
    tph = ph + PW'(32'h2000_0000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (adv) p_vld_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_side_q <= '{in_i.vec_x, in_i.vec_y, in_i.vec_z, in_i.axis_x, in_i.axis_y, in_i.axis_z};
      p_quad_q <= tph[PW-1 -: 2];
      p_res_q  <= $signed({3'b000, tph[PW-3:0]}) - (PW+1)'(33'sd536870912);
    end
  end

  // ---------------- CORDIC pipeline
  logic              c_vld_q  [1:Steps];
  side_t             c_side_q [1:Steps];
  logic [1:0]        c_quad_q [1:Steps];
  logic signed [CW-1:0] c_x_q [1:Steps];
  logic signed [CW-1:0] c_y_q [1:Steps];
  logic signed [PW:0]   c_z_q [1:Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    logic                 vld_in;
    side_t                side_in;
    logic [1:0]           quad_in;
    logic signed [CW-1:0] x_in, y_in;
    logic signed [PW:0]   z_in;
    logic signed [CW-1:0] dx, dy;
    if (i == 0) begin : g_head
      assign vld_in  = p_vld_q;
      assign side_in = p_side_q;
      assign quad_in = p_quad_q;
      assign x_in    = aavr_pkg::CordicGain;
      assign y_in    = '0;
      assign z_in    = p_res_q;
    end else begin : g_body
      assign vld_in  = c_vld_q[i];
      assign side_in = c_side_q[i];
      assign quad_in = c_quad_q[i];
      assign x_in    = c_x_q[i];
      assign y_in    = c_y_q[i];
      assign z_in    = c_z_q[i];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_vld_q[i+1] <= 1'b0;
      else if (adv) c_vld_q[i+1] <= vld_in;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_side_q[i+1] <= side_in;
        c_quad_q[i+1] <= quad_in;
        if (!z_in[PW]) begin
          c_x_q[i+1] <= x_in - dx;
          c_y_q[i+1] <= y_in + dy;
          c_z_q[i+1] <= z_in - aavr_pkg::atan_turn(i);
        end else begin
          c_x_q[i+1] <= x_in + dx;
          c_y_q[i+1] <= y_in - dy;
          c_z_q[i+1] <= z_in + aavr_pkg::atan_turn(i);
        end
      end
    end
  end

  // ---------------- post stages: valid/side shift line
  logic  v_q [NPost];
  side_t s_q [NPost];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NPost; k++) v_q[k] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= c_vld_q[Steps];
      for (int k = 1; k < NPost; k++) v_q[k] <= v_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= c_side_q[Steps];
      for (int k = 1; k < NPost; k++) s_q[k] <= s_q[k-1];
    end
  end

  // fix-up (stage 0)
  logic signed [CW-1:0] cs_c_q, cs_s_q;
  logic signed [CW-1:0] xf, yf;
  assign xf = c_x_q[Steps];
  assign yf = c_y_q[Steps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (c_quad_q[Steps])
        2'd0:    begin cs_c_q <= xf;  cs_s_q <= yf;  end
        2'd1:    begin cs_c_q <= -yf; cs_s_q <= xf;  end
        2'd2:    begin cs_c_q <= -xf; cs_s_q <= -yf; end
        default: begin cs_c_q <= yf;  cs_s_q <= -xf; end
      endcase
    end
  end

  // stage 1: axis products a_i*a_j, a_k*s, m
  logic signed [2*AW-1:0] aa_q [6]; // xx yy zz xy xz yz
  logic signed [PrW-1:0]  as_q [3];
  logic signed [CW:0]     m_q;
  logic signed [CW-1:0]   c1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      aa_q[0] <= s_q[0].ax * s_q[0].ax;
      aa_q[1] <= s_q[0].ay * s_q[0].ay;
      aa_q[2] <= s_q[0].az * s_q[0].az;
      aa_q[3] <= s_q[0].ax * s_q[0].ay;
      aa_q[4] <= s_q[0].ax * s_q[0].az;
      aa_q[5] <= s_q[0].ay * s_q[0].az;
      as_q[0] <= (PrW'(s_q[0].ax) * PrW'(cs_s_q)) >>> 14;
      as_q[1] <= (PrW'(s_q[0].ay) * PrW'(cs_s_q)) >>> 14;
      as_q[2] <= (PrW'(s_q[0].az) * PrW'(cs_s_q)) >>> 14;
      m_q     <= {aavr_pkg::OneQ30[CW-1], aavr_pkg::OneQ30} - {cs_c_q[CW-1], cs_c_q};
      c1_q    <= cs_c_q;
    end
  end

  // stage 2: (a_i a_j m) >> 28
  logic signed [PrW-1:0] am_q [6];
  logic signed [PrW-1:0] as2_q [3];
  logic signed [CW-1:0]  c2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) am_q[k] <= (PrW'(aa_q[k]) * PrW'(m_q)) >>> 28;
      for (int k = 0; k < 3; k++) as2_q[k] <= as_q[k];
      c2_q <= c1_q;
    end
  end

  // stage 3: matrix assembly
  logic signed [PrW-1:0] r_q [3][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0][0] <= am_q[0] + PrW'(c2_q);
      r_q[1][1] <= am_q[1] + PrW'(c2_q);
      r_q[2][2] <= am_q[2] + PrW'(c2_q);
      r_q[0][1] <= am_q[3] - as2_q[2];
      r_q[0][2] <= am_q[4] + as2_q[1];
      r_q[1][0] <= am_q[3] + as2_q[2];
      r_q[1][2] <= am_q[5] - as2_q[0];
      r_q[2][0] <= am_q[4] - as2_q[1];
      r_q[2][1] <= am_q[5] + as2_q[0];
    end
  end

  // stage 4: split vector products, R*v_lo and R*v_hi
  logic signed [COMP_WIDTH-1:0] vv [3];
  logic signed [PrW-1:0] ph_q [3][3];
  logic signed [PrW-1:0] pl_q [3][3];
  assign vv[0] = s_q[3].vx;
  assign vv[1] = s_q[3].vy;
  assign vv[2] = s_q[3].vz;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (COMP_WIDTH > 24)
            ph_q[i][j] <= r_q[i][j] * PrW'(signed'(vv[j][COMP_WIDTH-1 -: VhW]));
          else
            ph_q[i][j] <= r_q[i][j] * PrW'(vv[j][COMP_WIDTH-1] ? -1 : 0);
          pl_q[i][j] <= r_q[i][j] * $signed({1'b0, 24'(vv[j])});
        end
      end
    end
  end

  // stage 5: partial sums
  logic signed [PrW-1:0] hs_q [3];
  logic signed [PrW-1:0] ls_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hs_q[i] <= ph_q[i][0] + ph_q[i][1] + ph_q[i][2];
        ls_q[i] <= pl_q[i][0] + pl_q[i][1] + pl_q[i][2] + PrW'(64'sd536870912);
      end
    end
  end

  // stage 6: combine
  logic signed [PrW-1:0] tot_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) tot_q[i] <= (hs_q[i] + (ls_q[i] >>> 24)) >>> 6;
    end
  end

  // stage 7: saturate
  localparam logic signed [PrW-1:0] MaxV = PrW'((65'sd1 <<< (COMP_WIDTH-1)) - 65'sd1);
  localparam logic signed [PrW-1:0] MinV = -MaxV - PrW'(64'sd1);
  logic signed [COMP_WIDTH-1:0] o_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (tot_q[i] > MaxV) o_q[i] <= MaxV[COMP_WIDTH-1:0];
        else if (tot_q[i] < MinV) o_q[i] <= MinV[COMP_WIDTH-1:0];
        else o_q[i] <= tot_q[i][COMP_WIDTH-1:0];
      end
    end
  end

  assign out_o.valid = v_q[NPost-1];
  assign out_o.out_x = o_q[0];
  assign out_o.out_y = o_q[1];
  assign out_o.out_z = o_q[2];

  side_t unused_side;
  assign unused_side = s_q[NPost-1];

endmodule
